[sv/ped_pkg.sv]
// Shared types, widths and constants of the point-to-ellipse distance block.
package ped_pkg;

    localparam int W_COORD    = 24;  // Q16.8 coordinates and centers
    localparam int W_DIFF     = 25;  // point minus center
    localparam int W_TRIG     = 16;  // Q1.14 cosine and sine
    localparam int W_AXIS     = 23;  // Q15.8 semi-axes
    localparam int W_ROTP     = 41;  // difference times cosine or sine
    localparam int W_ROTS     = 42;  // sum of two rotation products
    localparam int W_UV       = 26;  // folded frame coordinates
    localparam int W_NUM      = 49;  // a*u and b*v, Q16
    localparam int W_SQR      = 46;  // a*a and b*b, Q16
    localparam int W_S        = 51;  // bisection variable, Q16
    localparam int W_DEN      = 53;  // signed divider denominator
    localparam int W_DREG     = 52;  // positive denominator / remainder
    localparam int W_Q        = 32;  // Q30 ratios, saturating at 2.0
    localparam int W_QSQ      = 33;  // rounded square of a ratio
    localparam int W_F        = 35;  // signed F in Q30
    localparam int W_ROOT     = 63;  // integer square root working width
    localparam int W_MOP      = 32;  // shared multiplier operand
    localparam int W_MPR      = 64;  // shared multiplier product
    localparam int W_XM       = 25;  // closest point coordinates, Q8
    localparam int W_ERR      = 28;  // signed coordinate error
    localparam int W_D2       = 56;  // sum of squared errors
    localparam int W_DIST     = 48;  // saturated squared distance
    localparam int W_CFG_IDX  = 3;
    localparam int W_CFG_DATA = 24;
    localparam int FRAC_BITS  = 30;  // fraction bits of the ratios
    localparam int W_DCNT     = 5;
    localparam int Q_DEPTH    = 2;   // entries in the front-to-back queue
    localparam int BISECT_STEPS_DEF = 48;

    localparam logic [W_UV-1:0]      COORD_MAX = {W_UV{1'b1}};
    localparam logic [W_Q-1:0]       RATIO_SAT = 32'h8000_0000;
    localparam logic signed [W_F-1:0] TOL_Q30  = 35'sd10737418;
    localparam logic signed [W_F-1:0] ONE_Q30  = 35'sd1073741824;
    localparam logic [W_MPR-1:0]     HALF_Q30  = 64'd536870912;
    localparam logic [W_DIST-1:0]    DIST_MAX  = {W_DIST{1'b1}};

    typedef enum logic [W_CFG_IDX-1:0] {
        CFG_CENTER_X   = 3'd0,
        CFG_CENTER_Y   = 3'd1,
        CFG_COS_ROT    = 3'd2,
        CFG_SIN_ROT    = 3'd3,
        CFG_SEMI_MINOR = 3'd4,
        CFG_SEMI_MAJOR = 3'd5
    } t_cfg_reg;

    typedef struct packed {
        logic signed [W_COORD-1:0] center_x;
        logic signed [W_COORD-1:0] center_y;
        logic signed [W_TRIG-1:0]  cos_rotation;
        logic signed [W_TRIG-1:0]  sin_rotation;
        logic [W_AXIS-1:0]         semi_minor;
        logic [W_AXIS-1:0]         semi_major;
    } t_ped_cfg;

    typedef struct packed {
        logic [W_UV-1:0] u;
        logic [W_UV-1:0] v;
    } t_ped_item;

    typedef struct packed {
        logic push;
        logic pop;
    } t_ped_qctl;

endpackage

[sv/ped_fifo.sv]
// Short queue that carries folded points from the front to the back.
module ped_fifo import ped_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_ped_qctl i_ctl,
    input  t_ped_item i_item,
    output t_ped_item o_item,
    output logic      o_empty,
    output logic      o_full
);

    localparam int W_PTR = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int W_CNT = $clog2(Q_DEPTH + 1);

    t_ped_item        r_mem [Q_DEPTH];
    logic [W_PTR-1:0] r_wr;
    logic [W_PTR-1:0] r_rd;
    logic [W_CNT-1:0] r_cnt;
    logic             w_push;
    logic             w_pop;

    assign o_empty = (r_cnt == '0);
    assign o_full  = (r_cnt == W_CNT'(Q_DEPTH));
    assign o_item  = r_mem[r_rd];
    assign w_push  = i_ctl.push && !o_full;
    assign w_pop   = i_ctl.pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_mem[r_wr] <= i_item;
                r_wr <= (r_wr == W_PTR'(Q_DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (w_pop) begin
                r_rd <= (r_rd == W_PTR'(Q_DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            case ({w_push, w_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

[sv/ped_div.sv]
// Restoring divider that forms one saturating Q30 ratio, one bit a cycle.
module ped_div import ped_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic [W_NUM-1:0]        i_num,
    input  logic signed [W_DEN-1:0] i_den,
    output logic                    o_done,
    output logic [W_Q-1:0]          o_quo
);

    logic                r_busy;
    logic                r_done;
    logic [W_DCNT-1:0]   r_cnt;
    logic [W_DREG-1:0]   r_d;
    logic [W_DREG-1:0]   r_r;
    logic [W_Q-1:0]      r_q;
    logic                r_force;
    logic [W_Q-1:0]      r_fval;

    logic [W_DREG-1:0]   w_dpos;
    logic [W_DEN-1:0]    w_num_ext;
    logic                w_ge1;
    logic                w_ge2;
    logic [W_DREG:0]     w_r2;
    logic                w_take;

    assign w_dpos    = i_den[W_DREG-1:0];
    assign w_num_ext = W_DEN'(i_num);
    assign w_ge1     = (w_num_ext >= {1'b0, w_dpos});
    assign w_ge2     = (w_num_ext >= {w_dpos, 1'b0});
    assign w_r2      = {r_r, 1'b0};
    assign w_take    = (w_r2 >= {1'b0, r_d});

    assign o_done = r_done;
    assign o_quo  = r_force ? r_fval : r_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                // Every case runs the full count so both ratios finish together.
                r_busy <= 1'b1;
                r_cnt  <= W_DCNT'(FRAC_BITS);
                r_d    <= w_dpos;
                if (i_num == '0) begin
                    r_force <= 1'b1;
                    r_fval  <= '0;
                end else if (i_den[W_DEN-1] || (i_den == '0) || w_ge2) begin
                    r_force <= 1'b1;
                    r_fval  <= RATIO_SAT;
                end else begin
                    r_force <= 1'b0;
                    r_fval  <= '0;
                end
                r_q <= W_Q'(w_ge1);
                r_r <= w_ge1 ? W_DREG'(w_num_ext - {1'b0, w_dpos}) : W_DREG'(i_num);
            end else if (r_busy) begin
                r_q <= {r_q[W_Q-2:0], w_take};
                r_r <= w_take ? W_DREG'(w_r2 - {1'b0, r_d}) : W_DREG'(w_r2);
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == W_DCNT'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

endmodule

[sv/ped_front.sv]
// Front end: takes a point, rotates it into the ellipse frame and folds it.
module ped_front import ped_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_ped_cfg           i_cfg,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [W_COORD-1:0] i_point_x,
    input  logic [W_COORD-1:0] i_point_y,
    output logic               o_push,
    output t_ped_item          o_item,
    input  logic               i_full
);

    typedef enum logic [1:0] {F_IDLE, F_MUL, F_FOLD, F_PUSH} t_fstate;

    t_fstate                  r_state;
    logic signed [W_DIFF-1:0] r_dx;
    logic signed [W_DIFF-1:0] r_dy;
    logic signed [W_ROTP-1:0] r_p_xc;
    logic signed [W_ROTP-1:0] r_p_ys;
    logic signed [W_ROTP-1:0] r_p_yc;
    logic signed [W_ROTP-1:0] r_p_xs;
    t_ped_item                r_item;
    logic signed [W_ROTS-1:0] w_xr;
    logic signed [W_ROTS-1:0] w_yr;

    // Magnitude, rounded half away from zero from Q22 to Q8, then clamped.
    function automatic logic [W_UV-1:0] fold(input logic signed [W_ROTS-1:0] val);
        logic [W_ROTS-1:0] mag;
        logic [W_ROTS:0]   rnd;
        logic [W_ROTS-14:0] sh;
        mag = val[W_ROTS-1] ? W_ROTS'(-val) : W_ROTS'(val);
        rnd = {1'b0, mag} + (W_ROTS+1)'(8192);
        sh  = rnd[W_ROTS:14];
        fold = (sh > (W_ROTS-13)'(COORD_MAX)) ? COORD_MAX : W_UV'(sh);
    endfunction

    assign w_xr    = W_ROTS'(r_p_xc) + W_ROTS'(r_p_ys);
    assign w_yr    = W_ROTS'(r_p_yc) - W_ROTS'(r_p_xs);
    assign o_ready = (r_state == F_IDLE);
    assign o_push  = (r_state == F_PUSH) && !i_full;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
        end else begin
            case (r_state)
                F_IDLE: begin
                    if (i_valid) begin
                        r_dx    <= W_DIFF'($signed(i_point_x)) - W_DIFF'(i_cfg.center_x);
                        r_dy    <= W_DIFF'($signed(i_point_y)) - W_DIFF'(i_cfg.center_y);
                        r_state <= F_MUL;
                    end
                end
                F_MUL: begin
                    r_p_xc  <= W_ROTP'(r_dx) * W_ROTP'(i_cfg.cos_rotation);
                    r_p_ys  <= W_ROTP'(r_dy) * W_ROTP'(i_cfg.sin_rotation);
                    r_p_yc  <= W_ROTP'(r_dy) * W_ROTP'(i_cfg.cos_rotation);
                    r_p_xs  <= W_ROTP'(r_dx) * W_ROTP'(i_cfg.sin_rotation);
                    r_state <= F_FOLD;
                end
                F_FOLD: begin
                    r_item.u <= fold(w_xr);
                    r_item.v <= fold(w_yr);
                    r_state  <= F_PUSH;
                end
                F_PUSH: begin
                    if (!i_full) begin
                        r_state <= F_IDLE;
                    end
                end
                default: r_state <= F_IDLE;
            endcase
        end
    end

endmodule

[sv/ped_back.sv]
// Back end: bounds, bisection with two dividers, and the squared distance.
module ped_back import ped_pkg::*; #(
    parameter int BISECT_STEPS = BISECT_STEPS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_ped_cfg          i_cfg,
    input  t_ped_item         i_item,
    input  logic              i_empty,
    output logic              o_pop,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [W_DIST-1:0] o_dist,
    output logic              o_conv
);

    localparam int W_STEP = $clog2(BISECT_STEPS + 1);
    localparam int W_K    = 5;
    localparam int W_SCNT = 5;

    typedef enum logic [4:0] {
        B_IDLE, B_A2, B_B2, B_NX, B_NY, B_SEED, B_HK, B_HX, B_HY, B_HSUM,
        B_SQRT, B_HSH, B_MID, B_DST, B_DIV, B_SQ0, B_SQ1, B_FEV, B_TST,
        B_XM, B_YM, B_EX, B_EY, B_EXX, B_DIST, B_OUT
    } t_bstate;

    t_bstate              r_state;
    logic [W_UV-1:0]      r_u;
    logic [W_UV-1:0]      r_v;
    logic [W_SQR-1:0]     r_a2;
    logic [W_SQR-1:0]     r_b2;
    logic [W_NUM-1:0]     r_nx;
    logic [W_NUM-1:0]     r_ny;
    logic [W_NUM-1:0]     r_hx;
    logic [W_NUM-1:0]     r_hy;
    logic [W_K-1:0]       r_k;
    logic [W_MPR-1:0]     r_prod;
    logic [W_MPR-1:0]     r_sqx;
    logic [W_ROOT-1:0]    r_rem;
    logic [W_ROOT-1:0]    r_root;
    logic [W_ROOT-1:0]    r_bit;
    logic [W_SCNT-1:0]    r_scnt;
    logic [W_S-1:0]       r_s0;
    logic [W_S-1:0]       r_s1;
    logic [W_S-1:0]       r_mid;
    logic [W_STEP-1:0]    r_steps;
    logic [W_Q-1:0]       r_q0;
    logic [W_Q-1:0]       r_q1;
    logic [W_QSQ-1:0]     r_sq0;
    logic signed [W_F-1:0] r_f;
    logic                 r_conv;
    logic [W_XM-1:0]      r_xm;
    logic [W_XM-1:0]      r_ym;
    logic signed [W_ERR-1:0] r_ex;
    logic signed [W_ERR-1:0] r_ey;
    logic [W_MPR-1:0]     r_exx;
    logic [W_DIST-1:0]    r_dres;
    logic                 r_ovalid;
    logic [W_DIST-1:0]    r_odist;
    logic                 r_oconv;

    logic [W_MOP-1:0]     w_ma;
    logic [W_MOP-1:0]     w_mb;
    logic [W_MPR-1:0]     w_rnd;
    logic [W_ROOT-1:0]    w_try;
    logic signed [W_DEN-1:0] w_den0;
    logic signed [W_DEN-1:0] w_den1;
    logic                 w_start;
    logic                 w_done0;
    logic                 w_done1;
    logic [W_Q-1:0]       w_quo0;
    logic [W_Q-1:0]       w_quo1;
    logic                 w_in_tol;
    logic                 w_fpos;
    logic [W_D2-1:0]      w_d2;
    logic                 w_load;
    logic [W_ERR-1:0]     w_abs_ex;
    logic [W_ERR-1:0]     w_abs_ey;

    assign w_rnd    = r_prod + HALF_Q30;
    assign w_try    = r_root + r_bit;
    assign w_start  = (r_state == B_DST);
    assign w_den0   = W_DEN'(r_mid) + W_DEN'(r_a2) - W_DEN'(r_b2);
    assign w_den1   = W_DEN'(r_mid);
    assign w_in_tol = (r_f <= TOL_Q30) && (r_f >= -TOL_Q30);
    assign w_fpos   = !r_f[W_F-1] && (r_f != '0);
    assign w_d2     = W_D2'(r_exx) + W_D2'(r_prod);
    assign w_load   = (r_state == B_OUT) && (!r_ovalid || i_ready);
    assign w_abs_ex = r_ex[W_ERR-1] ? W_ERR'(-r_ex) : W_ERR'(r_ex);
    assign w_abs_ey = r_ey[W_ERR-1] ? W_ERR'(-r_ey) : W_ERR'(r_ey);
    assign o_pop    = (r_state == B_IDLE) && !i_empty;
    assign o_valid  = r_ovalid;
    assign o_dist   = r_odist;
    assign o_conv   = r_oconv;

    // The two ratios of F are independent, so each gets its own divider.
    ped_div u_div_x (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_start),
        .i_num   (r_nx),
        .i_den   (w_den0),
        .o_done  (w_done0),
        .o_quo   (w_quo0)
    );

    ped_div u_div_y (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_start),
        .i_num   (r_ny),
        .i_den   (w_den1),
        .o_done  (w_done1),
        .o_quo   (w_quo1)
    );

    // Operands of the one shared multiplier; its product is registered.
    always_comb begin
        w_ma = '0;
        w_mb = '0;
        case (r_state)
            B_A2:  begin w_ma = W_MOP'(i_cfg.semi_major); w_mb = W_MOP'(i_cfg.semi_major); end
            B_B2:  begin w_ma = W_MOP'(i_cfg.semi_minor); w_mb = W_MOP'(i_cfg.semi_minor); end
            B_NX:  begin w_ma = W_MOP'(i_cfg.semi_major); w_mb = W_MOP'(r_u); end
            B_NY:  begin w_ma = W_MOP'(i_cfg.semi_minor); w_mb = W_MOP'(r_v); end
            B_HX:  begin w_ma = r_hx[W_MOP-1:0]; w_mb = r_hx[W_MOP-1:0]; end
            B_HY:  begin w_ma = r_hy[W_MOP-1:0]; w_mb = r_hy[W_MOP-1:0]; end
            B_SQ0: begin w_ma = r_q0; w_mb = r_q0; end
            B_SQ1: begin w_ma = r_q1; w_mb = r_q1; end
            B_XM:  begin w_ma = W_MOP'(i_cfg.semi_major); w_mb = r_q0; end
            B_YM:  begin w_ma = W_MOP'(i_cfg.semi_minor); w_mb = r_q1; end
            B_EY:  begin w_ma = W_MOP'(w_abs_ex); w_mb = W_MOP'(w_abs_ex); end
            B_EXX: begin w_ma = W_MOP'(w_abs_ey); w_mb = W_MOP'(w_abs_ey); end
            default: begin w_ma = '0; w_mb = '0; end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_prod <= W_MPR'(w_ma) * W_MPR'(w_mb);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= B_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            if (w_load) begin
                r_ovalid <= 1'b1;
            end else if (i_ready) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                B_IDLE: begin
                    if (!i_empty) begin
                        r_u     <= i_item.u;
                        r_v     <= i_item.v;
                        r_state <= B_A2;
                    end
                end
                B_A2: r_state <= B_B2;
                B_B2: begin
                    r_a2    <= W_SQR'(r_prod);
                    r_state <= B_NX;
                end
                B_NX: begin
                    r_b2    <= W_SQR'(r_prod);
                    r_state <= B_NY;
                end
                B_NY: begin
                    r_nx    <= W_NUM'(r_prod);
                    r_state <= B_SEED;
                end
                B_SEED: begin
                    r_ny    <= W_NUM'(r_prod);
                    r_s0    <= W_S'(r_prod[W_NUM-1:0]);
                    r_hx    <= r_nx;
                    r_hy    <= W_NUM'(r_prod);
                    r_k     <= '0;
                    r_state <= B_HK;
                end
                B_HK: begin
                    // Scale both legs until the larger is below 2^31.
                    if ((|r_hx[W_NUM-1:31]) || (|r_hy[W_NUM-1:31])) begin
                        r_hx <= r_hx >> 1;
                        r_hy <= r_hy >> 1;
                        r_k  <= r_k + 1'b1;
                    end else begin
                        r_state <= B_HX;
                    end
                end
                B_HX: r_state <= B_HY;
                B_HY: begin
                    r_sqx   <= r_prod;
                    r_state <= B_HSUM;
                end
                B_HSUM: begin
                    r_rem   <= W_ROOT'(r_sqx + r_prod);
                    r_root  <= '0;
                    r_bit   <= W_ROOT'(1) << (W_ROOT - 1);
                    r_scnt  <= '0;
                    r_state <= B_SQRT;
                end
                B_SQRT: begin
                    if (r_rem >= w_try) begin
                        r_rem  <= r_rem - w_try;
                        r_root <= (r_root >> 1) + r_bit;
                    end else begin
                        r_root <= r_root >> 1;
                    end
                    r_bit  <= r_bit >> 2;
                    r_scnt <= r_scnt + 1'b1;
                    if (r_scnt == {W_SCNT{1'b1}}) begin
                        r_state <= B_HSH;
                    end
                end
                B_HSH: begin
                    if (r_k != '0) begin
                        r_root <= r_root << 1;
                        r_k    <= r_k - 1'b1;
                    end else begin
                        r_s1    <= r_root[W_S-1:0];
                        r_steps <= '0;
                        r_state <= B_MID;
                    end
                end
                B_MID: begin
                    r_mid   <= W_S'((W_S+1)'(r_s0) + (W_S+1)'(r_s1) >> 1);
                    r_state <= B_DST;
                end
                B_DST: r_state <= B_DIV;
                B_DIV: begin
                    if (w_done0) begin
                        r_q0    <= w_quo0;
                        r_q1    <= w_quo1;
                        r_state <= B_SQ0;
                    end
                end
                B_SQ0: r_state <= B_SQ1;
                B_SQ1: begin
                    r_sq0   <= W_QSQ'(w_rnd >> FRAC_BITS);
                    r_state <= B_FEV;
                end
                B_FEV: begin
                    r_f <= W_F'(r_sq0) + W_F'(W_QSQ'(w_rnd >> FRAC_BITS)) - ONE_Q30;
                    r_state <= B_TST;
                end
                B_TST: begin
                    if (w_in_tol || (r_steps == W_STEP'(BISECT_STEPS))) begin
                        r_conv  <= w_in_tol;
                        r_state <= B_XM;
                    end else begin
                        if (w_fpos) begin
                            r_s0 <= r_mid;
                        end else begin
                            r_s1 <= r_mid;
                        end
                        r_steps <= r_steps + 1'b1;
                        r_state <= B_MID;
                    end
                end
                B_XM: r_state <= B_YM;
                B_YM: begin
                    r_xm    <= W_XM'(w_rnd >> FRAC_BITS);
                    r_state <= B_EX;
                end
                B_EX: begin
                    r_ym    <= W_XM'(w_rnd >> FRAC_BITS);
                    r_ex    <= W_ERR'(r_u) - W_ERR'(r_xm);
                    r_state <= B_EY;
                end
                B_EY: begin
                    r_ey    <= W_ERR'(r_v) - W_ERR'(r_ym);
                    r_state <= B_EXX;
                end
                B_EXX: begin
                    r_exx   <= r_prod;
                    r_state <= B_DIST;
                end
                B_DIST: begin
                    r_dres  <= (w_d2 > W_D2'(DIST_MAX)) ? DIST_MAX : W_DIST'(w_d2);
                    r_state <= B_OUT;
                end
                B_OUT: begin
                    if (w_load) begin
                        r_odist  <= r_dres;
                        r_oconv  <= r_conv;
                        r_state  <= B_IDLE;
                    end
                end
                default: r_state <= B_IDLE;
            endcase
        end
    end

`ifndef ASSERT_OFF
    a_div_lockstep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_done0 == w_done1)
        else $error("ratio dividers finished on different cycles");

    a_step_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == B_TST |-> r_steps <= W_STEP'(BISECT_STEPS))
        else $error("bisection step count passed its limit");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load |-> (!r_ovalid || i_ready))
        else $error("result register loaded while holding an untaken result");

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> !i_empty)
        else $error("queue popped while empty");
`endif

endmodule

[sv/point_ellipse_distance_bisection.sv]
// Top level of the point-to-ellipse squared distance block.
//
// Each accepted point (Q16.8) is moved into the frame of the configured
// rotated ellipse, folded into the first quadrant and handed through a
// two-entry queue to the solver, so a new point can be taken while the
// solver is still busy or while a result waits on the output. The solver
// works on one point at a time. It forms the two bisection bounds (the lower
// one from b*v, the upper one from an integer square root of 32 steps), then
// bisects: every step runs the two ratio dividers side by side, which set
// the pace of the step. Before that, the upper-bound legs are halved k times
// (k at most 18) to bring them below 2^31; the bisection takes n steps, the
// number needed to bring |F| within 0.01, at most BISECT_STEPS (48 by
// default). The result is the squared distance in Q32.16, saturating, on
// tdata, and the converged flag on tuser. Configuration registers may be
// written only while no point is in flight.
module point_ellipse_distance_bisection import ped_pkg::*; #(
    parameter int BISECT_STEPS = BISECT_STEPS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [47:0]           s_axis_tdata,  // point_x [23:0], point_y [47:24]
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [47:0]           m_axis_tdata,  // distance_sq [47:0]
    output logic                  m_axis_tuser,  // converged [0]
    input  logic                  i_cfg_we,
    input  logic [W_CFG_IDX-1:0]  i_cfg_index,
    input  logic [W_CFG_DATA-1:0] i_cfg_data
);

    t_ped_cfg  r_cfg;
    t_ped_item w_fitem;
    t_ped_item w_qitem;
    t_ped_qctl w_qctl;
    logic      w_push;
    logic      w_pop;
    logic      w_empty;
    logic      w_full;

    // Register file; indexes beyond the last register are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.center_x     <= '0;
            r_cfg.center_y     <= '0;
            r_cfg.cos_rotation <= 16'sd16384;
            r_cfg.sin_rotation <= '0;
            r_cfg.semi_minor   <= W_AXIS'(256);
            r_cfg.semi_major   <= W_AXIS'(256);
        end else if (i_cfg_we) begin
            case (t_cfg_reg'(i_cfg_index))
                CFG_CENTER_X:   r_cfg.center_x     <= i_cfg_data[W_COORD-1:0];
                CFG_CENTER_Y:   r_cfg.center_y     <= i_cfg_data[W_COORD-1:0];
                CFG_COS_ROT:    r_cfg.cos_rotation <= i_cfg_data[W_TRIG-1:0];
                CFG_SIN_ROT:    r_cfg.sin_rotation <= i_cfg_data[W_TRIG-1:0];
                CFG_SEMI_MINOR: r_cfg.semi_minor   <= i_cfg_data[W_AXIS-1:0];
                CFG_SEMI_MAJOR: r_cfg.semi_major   <= i_cfg_data[W_AXIS-1:0];
                default: ;
            endcase
        end
    end

    // Front end: rotation and folding of the incoming point.
    ped_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_valid   (s_axis_tvalid),
        .o_ready   (s_axis_tready),
        .i_point_x (s_axis_tdata[23:0]),
        .i_point_y (s_axis_tdata[47:24]),
        .o_push    (w_push),
        .o_item    (w_fitem),
        .i_full    (w_full)
    );

    assign w_qctl.push = w_push;
    assign w_qctl.pop  = w_pop;

    // The queue lets the front take new points while the solver is busy.
    ped_fifo u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_qctl),
        .i_item  (w_fitem),
        .o_item  (w_qitem),
        .o_empty (w_empty),
        .o_full  (w_full)
    );

    // Solver with its own output register.
    ped_back #(
        .BISECT_STEPS (BISECT_STEPS)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_item  (w_qitem),
        .i_empty (w_empty),
        .o_pop   (w_pop),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_dist  (m_axis_tdata),
        .o_conv  (m_axis_tuser)
    );

endmodule

[tb/sv/testbench.sv]
// Self-checking testbench for the point-to-ellipse squared distance block.
module testbench import ped_pkg::*;;

    timeunit 1ns;
    timeprecision 1ps;

    typedef longint unsigned u64_t;

    typedef struct {
        logic [47:0] dist_sq;
        logic        conv;
    } dist_result_t;

    // Fixed-point constants of the solver: tolerance and one in Q30, ratio clamp.
    localparam longint     TOL_F   = 64'd10737418;
    localparam longint     ONE_F   = 64'd1073741824;
    localparam u64_t       Q_CLAMP = 64'd2147483648;
    localparam u64_t       UV_CLAMP = 64'd67108863;
    localparam u64_t       D_CLAMP = 64'd281474976710655;
    localparam int         STEP_LIMIT = 48;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [47:0]           s_axis_tdata;   // point_x [23:0], point_y [47:24]
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [47:0]           m_axis_tdata;   // distance_sq [47:0]
    logic                  m_axis_tuser;   // converged [0]
    logic                  i_cfg_we;
    logic [W_CFG_IDX-1:0]  i_cfg_index;
    logic [W_CFG_DATA-1:0] i_cfg_data;

    point_ellipse_distance_bisection i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    // Shadow copy of the ellipse registers, updated when a write lands.
    logic signed [23:0] ell_cx, ell_cy;
    logic signed [15:0] ell_cos, ell_sin;
    logic [22:0]        ell_b, ell_a;

    logic [47:0]  point_q[$];       // points waiting to be sent
    dist_result_t dist_due[$];      // predicted results, oldest first
    int           fail_cnt;
    bit           point_taken;      // set at the edge where a point is accepted
    bit           sending;          // driver currently holds a point on the bus
    int           send_gap;
    int           stall_len;
    bit           steady;           // when set, neither side idles

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // ---------------------------------------------------------------------
    // Predictor of the solver in Q-format integer arithmetic.
    // ---------------------------------------------------------------------

    // Magnitude of a Q1.14-scaled rotation product, rounded to Q8 and clamped.
    function automatic u64_t fold_q8(longint v);
        u64_t mag;
        mag = (v < 0) ? u64_t'(-v) : u64_t'(v);
        mag = (mag + 64'd8192) >> 14;
        return (mag > UV_CLAMP) ? UV_CLAMP : mag;
    endfunction

    function automatic u64_t int_sqrt(u64_t x);
        u64_t r, bitv;
        r = 0;
        bitv = 64'd1 << 62;
        while (bitv > x) bitv >>= 2;
        while (bitv != 0) begin
            if (x >= r + bitv) begin
                x -= r + bitv;
                r = (r >> 1) + bitv;
            end else begin
                r >>= 1;
            end
            bitv >>= 2;
        end
        return r;
    endfunction

    // Upper bisection bound: scaled-down hypot so the squares fit in 64 bits.
    function automatic u64_t upper_bound(u64_t x, u64_t y);
        u64_t m;
        int   k;
        m = (x > y) ? x : y;
        k = 0;
        while ((m >> k) >= (64'd1 << 31)) k++;
        x >>= k;
        y >>= k;
        return int_sqrt(x * x + y * y) << k;
    endfunction

    // Q30 quotient, truncated; zero for a zero numerator, clamped at 2.0
    // for a nonpositive denominator or an overflowing quotient.
    function automatic u64_t q30_ratio(u64_t num, longint den);
        u64_t d, r, q;
        if (num == 0) return 0;
        if (den <= 0) return Q_CLAMP;
        d = u64_t'(den);
        if (num >= 2 * d) return Q_CLAMP;
        q = (num >= d) ? 1 : 0;
        r = num - q * d;
        for (int i = 0; i < 30; i++) begin
            r <<= 1;
            q <<= 1;
            if (r >= d) begin
                r -= d;
                q |= 1;
            end
        end
        return q;
    endfunction

    function automatic longint secular_f(u64_t s, u64_t nx, u64_t ny, u64_t a2, u64_t b2,
                                         output u64_t q0, output u64_t q1);
        u64_t sq0, sq1;
        q0 = q30_ratio(nx, longint'(s + a2) - longint'(b2));
        q1 = q30_ratio(ny, longint'(s));
        sq0 = (q0 * q0 + (64'd1 << 29)) >> 30;
        sq1 = (q1 * q1 + (64'd1 << 29)) >> 30;
        return longint'(sq0 + sq1) - ONE_F;
    endfunction

    function automatic dist_result_t predict_distance(logic [47:0] pt);
        dist_result_t res;
        longint dx, dy, f, ex, ey;
        u64_t   u, v, a, b, nx, ny, s0, s1, mid, q0, q1, xm, ym, d;
        int     steps;
        dx = longint'($signed(pt[23:0])) - longint'(ell_cx);
        dy = longint'($signed(pt[47:24])) - longint'(ell_cy);
        u  = fold_q8(dx * longint'(ell_cos) + dy * longint'(ell_sin));
        v  = fold_q8(dy * longint'(ell_cos) - dx * longint'(ell_sin));
        a  = u64_t'(ell_a);
        b  = u64_t'(ell_b);
        nx = a * u;
        ny = b * v;
        s0 = ny;
        s1 = upper_bound(nx, ny);
        mid = (s0 + s1) >> 1;
        f = secular_f(mid, nx, ny, a * a, b * b, q0, q1);
        steps = 0;
        while ((f > TOL_F || f < -TOL_F) && steps < STEP_LIMIT) begin
            if (f > 0) s0 = mid;
            else s1 = mid;
            mid = (s0 + s1) >> 1;
            f = secular_f(mid, nx, ny, a * a, b * b, q0, q1);
            steps++;
        end
        xm = (a * q0 + (64'd1 << 29)) >> 30;
        ym = (b * q1 + (64'd1 << 29)) >> 30;
        ex = longint'(u) - longint'(xm);
        ey = longint'(v) - longint'(ym);
        d  = u64_t'(ex * ex) + u64_t'(ey * ey);
        res.dist_sq = (d > D_CLAMP) ? D_CLAMP[47:0] : d[47:0];
        res.conv    = (f <= TOL_F && f >= -TOL_F);
        return res;
    endfunction

    // Idle lengths: mostly none or short, occasionally a long pause.
    function automatic int pick_idle();
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 50) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 80);
    endfunction

    // ---------------------------------------------------------------------
    // Point driver: changes inputs on the falling edge only.
    // ---------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (sending && point_taken) begin
                sending = 0;
                send_gap = pick_idle();
            end
            if (!sending) begin
                if (send_gap > 0) begin
                    send_gap--;
                end else if (point_q.size() > 0) begin
                    s_axis_tdata <= point_q.pop_front();
                    sending = 1;
                end
            end
            point_taken = 0;
            s_axis_tvalid <= sending;
        end
    end

    // Result receiver: back-pressure in random stretches.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else if (stall_len > 0) begin
            stall_len--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
            if (!steady && $urandom_range(0, 7) == 0) stall_len = pick_idle();
        end
    end

    // ---------------------------------------------------------------------
    // Monitor: predicts on each accepted point, checks each accepted result.
    // ---------------------------------------------------------------------
    always @(posedge i_clk) begin
        dist_result_t want;
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) begin
                dist_due.push_back(predict_distance(s_axis_tdata));
                point_taken = 1;
            end
            if (m_axis_tvalid && m_axis_tready) begin
                if (dist_due.size() == 0) begin
                    $error("unexpected result: distance_sq %0d converged %0d",
                           m_axis_tdata, m_axis_tuser);
                    fail_cnt++;
                end else begin
                    want = dist_due.pop_front();
                    if (m_axis_tdata !== want.dist_sq) begin
                        $error("distance_sq expected %0d actual %0d",
                               want.dist_sq, m_axis_tdata);
                        fail_cnt++;
                    end
                    if (m_axis_tuser !== want.conv) begin
                        $error("converged expected %0d actual %0d",
                               want.conv, m_axis_tuser);
                        fail_cnt++;
                    end
                end
            end
        end
    end

    // ---------------------------------------------------------------------
    // Stimulus
    // ---------------------------------------------------------------------

    // One register write; the shadow copy follows at the same edge.
    task automatic write_reg(t_cfg_reg idx, logic [23:0] val);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        case (idx)
            CFG_CENTER_X:   ell_cx  = val;
            CFG_CENTER_Y:   ell_cy  = val;
            CFG_COS_ROT:    ell_cos = val[15:0];
            CFG_SIN_ROT:    ell_sin = val[15:0];
            CFG_SEMI_MINOR: ell_b   = val[22:0];
            CFG_SEMI_MAJOR: ell_a   = val[22:0];
            default: ;
        endcase
    endtask

    task automatic set_ellipse(int cx, int cy, int c, int s, int b, int a);
        write_reg(CFG_CENTER_X, cx[23:0]);
        write_reg(CFG_CENTER_Y, cy[23:0]);
        write_reg(CFG_COS_ROT, {8'd0, c[15:0]});
        write_reg(CFG_SIN_ROT, {8'd0, s[15:0]});
        write_reg(CFG_SEMI_MINOR, {1'b0, b[22:0]});
        write_reg(CFG_SEMI_MAJOR, {1'b0, a[22:0]});
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Every point sent has produced its result and nothing is on the bus.
    task automatic wait_idle();
        while (point_q.size() != 0 || sending || dist_due.size() != 0) @(posedge i_clk);
        repeat (5) @(posedge i_clk);
    endtask

    function automatic void add_point(int x, int y);
        point_q.push_back({y[23:0], x[23:0]});
    endfunction

    // Mostly points around the ellipse at its own scale, some anywhere.
    task automatic random_points(int count);
        int span, x, y;
        span = (ell_a > ell_b) ? ell_a : ell_b;
        if (span < 256) span = 256;
        if (span > 2000000) span = 2000000;
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(0, 4) == 0) begin
                add_point($urandom(), $urandom());
            end else begin
                x = int'(ell_cx) + $urandom_range(0, 4 * span) - 2 * span;
                y = int'(ell_cy) + $urandom_range(0, 4 * span) - 2 * span;
                if (x > 8388607) x = 8388607;
                if (x < -8388608) x = -8388608;
                if (y > 8388607) y = 8388607;
                if (y < -8388608) y = -8388608;
                add_point(x, y);
            end
        end
    endtask

    initial begin
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        m_axis_tready = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_index   = CFG_CENTER_X;
        i_cfg_data    = '0;
        fail_cnt      = 0;
        point_taken   = 0;
        sending       = 0;
        send_gap      = 0;
        stall_len     = 0;
        steady        = 0;
        // Register values after reset: unit circle at the origin.
        ell_cx = 0; ell_cy = 0; ell_cos = 16384; ell_sin = 0; ell_b = 256; ell_a = 256;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed points on the reset circle: the center itself, points on
        // and off the axes, and the corners of the coordinate range.
        add_point(0, 0);
        add_point(256, 0);
        add_point(0, 256);
        add_point(-256, 0);
        add_point(0, -512);
        add_point(128, 128);
        add_point(1, 0);
        add_point(0, 1);
        add_point(-1, -1);
        add_point(512, -300);
        add_point(181, 181);
        add_point(8388607, 8388607);
        add_point(-8388608, -8388608);
        add_point(8388607, -8388608);
        add_point(-8388608, 8388607);
        add_point(8388607, 0);
        add_point(0, -8388608);
        wait_idle();

        // Each pass loads an ellipse, then runs a batch of random points.
        // Some passes push the registers to their extremes: degenerate axes,
        // axes given in either order, rotations outside the unit range.
        for (int ph = 0; ph < 8; ph++) begin
            steady = (ph % 3 == 2);
            case (ph)
                0: set_ellipse(0, 0, 16384, 0, 256, 512);
                1: set_ellipse(1000, -2000, 14189, 8192, 3000, 9000);
                2: set_ellipse(8388607, -8388608, -16384, 16384, 0, 8388607);
                3: set_ellipse(-8388608, 8388607, 32767, -32768, 8388607, 0);
                4: set_ellipse(-5000, 700, -11585, 11585, 5000, 5000);
                5: set_ellipse(300, 300, -5604, -15396, 12345, 700);
                6: set_ellipse($urandom(), $urandom(), $urandom(), $urandom(),
                               $urandom(), $urandom());
                default: set_ellipse(-123456, 65432, 11585, 11585, 64, 40000);
            endcase
            if (ph == 2 || ph == 3) begin
                // One is the center; the other overflows and must saturate.
                add_point(-8388608, 8388607);
                add_point(8388607, -8388608);
            end
            random_points(216);
            wait_idle();
        end

        repeat (100) @(posedge i_clk);
        if (fail_cnt == 0) begin
            $display("point_ellipse_distance_bisection verification clean");
        end else begin
            $display("point_ellipse_distance_bisection verification failed");
        end
        $finish;
    end

    // The limit lies far beyond the worst case per point plus stalls.
    initial begin
        #200ms;
        $display("point_ellipse_distance_bisection verification failed");
        $finish;
    end

endmodule
